// ===== sv/hbp_pkg.sv =====
// hbp_pkg: item types, register codes and fixed-point constants of the
// halo billboard projection unit
// depends on nothing; used by halo_billboard_projection_unit
package hbp_pkg;

   // one point light as it enters the block
   typedef struct packed {
      logic signed [31:0] light_x;
      logic signed [31:0] light_y;
      logic signed [31:0] light_z;
      logic [31:0]        inverse_radius_sq;
      logic [15:0]        light_intensity;
      logic [15:0]        red_premul;
      logic [15:0]        green_premul;
      logic [15:0]        blue_premul;
      logic [15:0]        halo_fraction;
   } req_type;

   // one projected quad
   typedef struct packed {
      logic signed [31:0] screen_left;
      logic signed [31:0] screen_right;
      logic signed [31:0] screen_top;
      logic signed [31:0] screen_bottom;
      logic [15:0]        shade_red;
      logic [15:0]        shade_green;
      logic [15:0]        shade_blue;
      logic [14:0]        shade_alpha;
      logic [28:0]        inverse_depth;
      logic [15:0]        depth_value;
   } rsp_type;

   // register word index, byte address is four times this
   typedef enum logic [2:0] {
      REG_CAMERA_X     = 3'd0,
      REG_CAMERA_Y     = 3'd1,
      REG_CAMERA_Z     = 3'd2,
      REG_VIEW_COSINE  = 3'd3,
      REG_VIEW_SINE    = 3'd4,
      REG_FOCAL_HORIZ  = 3'd5,
      REG_FOCAL_VERT   = 3'd6,
      REG_NEAR_BIAS    = 3'd7
   } csr_index_type;

   // register reset values
   localparam logic [15:0] COSINE_RESET = 16'd16384;
   localparam logic [15:0] FOCAL_RESET  = 16'd2560;
   localparam logic [15:0] BIAS_RESET   = 16'd96;

   // shading constants in Q0.16
   localparam logic [15:0] C_045 = 16'd29491;
   localparam logic [15:0] C_055 = 16'd36045;
   localparam logic [14:0] C_030 = 15'd19661;
   localparam logic [14:0] C_042 = 15'd27525;

   // quads nearer than 12.0 map units are dropped
   localparam logic signed [35:0] NEAR_LIMIT = 36'sd786432;

endpackage

// ===== sv/hbp_div_pipe.sv =====
// hbp_div_pipe: pipelined unsigned restoring divider, one quotient bit per stage
// self-contained; instantiated by halo_billboard_projection_unit
module hbp_div_pipe #(
   parameter int NUM_W = 49,
   parameter int DEN_W = 32,
   parameter int QUO_W = 33
) (
   input  logic             clock,
   input  logic             advance,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic [QUO_W-1:0] quot
);

   // partial remainder and divisor per stage, the last stage keeps only bits
   logic [DEN_W-1:0] rem_ff [QUO_W-1];
   logic [DEN_W-1:0] den_ff [QUO_W-1];
   // low numerator bits shift out at the top while quotient bits shift in
   logic [QUO_W-1:0] low_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      logic [DEN_W-1:0] rem_p;
      logic [DEN_W-1:0] den_p;
      logic [QUO_W-1:0] low_p;
      logic [QUO_W-1:0] low_in;
      logic [DEN_W:0]   trial;
      logic             ge;

      // stage inputs
      if (k == 0) begin : g_first
         assign rem_p = DEN_W'(numer >> QUO_W);
         assign low_p = numer[QUO_W-1:0];
         assign den_p = denom;
      end else begin : g_next
         assign rem_p = rem_ff[k-1];
         assign low_p = low_ff[k-1];
         assign den_p = den_ff[k-1];
      end

      // trial subtract of one bit
      always_comb begin
         trial  = {rem_p, low_p[QUO_W-1]};
         ge     = trial >= {1'b0, den_p};
         low_in = {low_p[QUO_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            low_ff[k] <= low_in;
         end
      end

      // remainder only matters while more bits follow
      if (k < QUO_W - 1) begin : g_rem
         logic [DEN_W:0]   diff;
         logic [DEN_W-1:0] rem_in;

         always_comb begin
            diff   = trial - {1'b0, den_p};
            rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[k] <= rem_in;
               den_ff[k] <= den_p;
            end
         end
      end
   end

   assign quot = low_ff[QUO_W-1];

endmodule

// ===== sv/halo_billboard_projection_unit.sv =====
// halo_billboard_projection_unit: top level, camera registers and projection pipeline
// depends on hbp_pkg and hbp_div_pipe

// Takes one point light per clock while req_stall is low and returns
// either nothing (quad nearer than 12 units or wholly off screen)
// or one screen-space halo quad with its colour, alpha, inverse depth and
// biased z. The latency is set by the longest chain: a 32-step square root
// of the inverse squared radius, a 33-bit radius divide, and the 44-bit
// signed projection divides, each one bit per pipeline stage. The pipeline
// holds only while a finished item waits on rsp_stall; there is no startup
// sweep. Registers are written over the APB port at byte address four times
// the register index and should only be changed while no light is in flight.
module halo_billboard_projection_unit #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  hbp_pkg::req_type req_item,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output hbp_pkg::rsp_type rsp_item,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [4:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready
);

   // stage indexes, the input register is stage zero
   localparam int SQRT_STEPS = 32;
   localparam int RAD_Q      = 33;
   localparam int HUE_Q      = 32;
   localparam int IW_Q       = 29;
   localparam int PROJ_Q     = 44;
   localparam int T_GEO      = 3;
   localparam int T_RAD      = SQRT_STEPS + RAD_Q;
   localparam int T_P3       = T_RAD + 5;
   localparam int T_PROJ     = T_P3 + PROJ_Q;
   localparam int T_CLR      = HUE_Q + 2;
   localparam int PIPE_LAST  = T_PROJ + 1;
   localparam int GEO_DELAY  = T_RAD - T_GEO;
   localparam int IW_DELAY   = PROJ_Q - IW_Q;
   localparam int CLR_DELAY  = PIPE_LAST - T_CLR;

   localparam logic signed [46:0] WIDTH_LIM  = 47'(SCREEN_WIDTH) <<< 16;
   localparam logic signed [46:0] HEIGHT_LIM = 47'(SCREEN_HEIGHT) <<< 16;
   localparam logic signed [46:0] HALF_W     = 47'(SCREEN_WIDTH) <<< 15;
   localparam logic signed [46:0] HALF_H     = 47'(SCREEN_HEIGHT) <<< 15;
   localparam logic signed [46:0] EDGE_MAX   = 47'sh0000_7FFF_FFFF;
   localparam logic signed [46:0] EDGE_MIN   = -47'sh0000_8000_0000;
   localparam logic [48:0]        POW48      = 49'h1_0000_0000_0000;
   localparam logic [32:0]        POW32      = 33'h1_0000_0000;

   typedef struct packed {
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [32:0] dz;
      logic [15:0]        hf;
      logic               irs_zero;
   } g1_type;

   typedef struct packed {
      logic signed [48:0] p_dc;
      logic signed [48:0] p_ds;
      logic signed [48:0] p_xs;
      logic signed [48:0] p_yc;
      logic signed [32:0] dz;
      logic [15:0]        hf;
      logic               irs_zero;
   } g2_type;

   typedef struct packed {
      logic signed [35:0] depth;
      logic signed [35:0] offs;
      logic signed [32:0] dz;
      logic [15:0]        hf;
      logic               irs_zero;
      logic               depth_ok;
   } geo_type;

   typedef struct packed {
      logic [48:0] prod;
      geo_type     geo;
   } h1_type;

   typedef struct packed {
      logic [30:0] half;
      geo_type     geo;
   } h2_type;

   typedef struct packed {
      logic signed [33:0] qa;
      logic signed [33:0] qb;
      logic signed [35:0] offs;
      logic [30:0]        half;
      logic [34:0]        depth;
      logic               depth_ok;
   } p1_type;

   typedef struct packed {
      logic signed [52:0] mo;
      logic [46:0]        mh;
      logic signed [50:0] ma;
      logic signed [50:0] mb;
      logic [34:0]        depth;
      logic               depth_ok;
   } p2_type;

   typedef struct packed {
      logic sign_o;
      logic sign_a;
      logic sign_b;
      logic depth_ok;
   } side_type;

   typedef struct packed {
      logic [62:0] num_o;
      logic [62:0] num_h;
      logic [62:0] num_a;
      logic [62:0] num_b;
      logic [34:0] depth;
      side_type    side;
   } p3_type;

   typedef struct packed {
      logic signed [46:0] left;
      logic signed [46:0] right;
      logic signed [46:0] top;
      logic signed [46:0] bottom;
      logic [44:0]        zb;
      logic [28:0]        iw;
      logic               depth_ok;
   } e1_type;

   typedef struct packed {
      logic        inten_zero;
      logic [14:0] alpha;
   } clr0_type;

   typedef struct packed {
      logic [47:0] hr;
      logic [47:0] hg;
      logic [47:0] hb;
      logic [14:0] alpha;
   } c1_type;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [14:0] alpha;
   } clr_type;

   // saturate a wide edge to the signed 32-bit range
   function automatic logic [31:0] clamp_edge(input logic signed [46:0] v);
      logic [31:0] r;
      if (v > EDGE_MAX) begin
         r = 32'h7FFF_FFFF;
      end else if (v < EDGE_MIN) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   logic advance;

   // configuration registers
   logic [31:0] cam_x_ff, cam_y_ff, cam_z_ff;
   logic [15:0] cos_ff, sin_ff, fh_ff, fv_ff, nb_ff;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff <= '0;
         cam_y_ff <= '0;
         cam_z_ff <= '0;
         cos_ff   <= hbp_pkg::COSINE_RESET;
         sin_ff   <= '0;
         fh_ff    <= hbp_pkg::FOCAL_RESET;
         fv_ff    <= hbp_pkg::FOCAL_RESET;
         nb_ff    <= hbp_pkg::BIAS_RESET;
      end else if (csr_write) begin
         unique case (hbp_pkg::csr_index_type'(csr_paddr[4:2]))
            hbp_pkg::REG_CAMERA_X:    cam_x_ff <= csr_pwdata;
            hbp_pkg::REG_CAMERA_Y:    cam_y_ff <= csr_pwdata;
            hbp_pkg::REG_CAMERA_Z:    cam_z_ff <= csr_pwdata;
            hbp_pkg::REG_VIEW_COSINE: cos_ff   <= csr_pwdata[15:0];
            hbp_pkg::REG_VIEW_SINE:   sin_ff   <= csr_pwdata[15:0];
            hbp_pkg::REG_FOCAL_HORIZ: fh_ff    <= csr_pwdata[15:0];
            hbp_pkg::REG_FOCAL_VERT:  fv_ff    <= csr_pwdata[15:0];
            hbp_pkg::REG_NEAR_BIAS:   nb_ff    <= csr_pwdata[15:0];
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (hbp_pkg::csr_index_type'(csr_paddr[4:2]))
         hbp_pkg::REG_CAMERA_X:    csr_prdata = cam_x_ff;
         hbp_pkg::REG_CAMERA_Y:    csr_prdata = cam_y_ff;
         hbp_pkg::REG_CAMERA_Z:    csr_prdata = cam_z_ff;
         hbp_pkg::REG_VIEW_COSINE: csr_prdata = {16'd0, cos_ff};
         hbp_pkg::REG_VIEW_SINE:   csr_prdata = {16'd0, sin_ff};
         hbp_pkg::REG_FOCAL_HORIZ: csr_prdata = {16'd0, fh_ff};
         hbp_pkg::REG_FOCAL_VERT:  csr_prdata = {16'd0, fv_ff};
         hbp_pkg::REG_NEAR_BIAS:   csr_prdata = {16'd0, nb_ff};
      endcase
   end

   // whole pipeline holds only while a finished item is refused
   logic           rsp_valid_ff, rsp_valid_in;
   hbp_pkg::rsp_type rsp_ff, rsp_in;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // valid bits travel with the items
   logic [PIPE_LAST:0] valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[PIPE_LAST-1:0], req_valid};
      end
   end

   // input register
   hbp_pkg::req_type in_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         in_ff <= req_item;
      end
   end

   // square root of inverse_radius_sq * 2^32, two radicand bits per stage
   logic [33:0] sq_rem_ff  [SQRT_STEPS-1];
   logic [31:0] sq_bits_ff [SQRT_STEPS-1];
   logic [31:0] sq_root_ff [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      logic [33:0] rem_p;
      logic [31:0] bits_p;
      logic [31:0] root_p;
      logic [35:0] rs, tr;
      logic        ge;
      logic [31:0] root_in;

      if (k == 0) begin : g_first
         assign rem_p  = '0;
         assign bits_p = in_ff.inverse_radius_sq;
         assign root_p = '0;
      end else begin : g_next
         assign rem_p  = sq_rem_ff[k-1];
         assign bits_p = sq_bits_ff[k-1];
         assign root_p = sq_root_ff[k-1];
      end

      always_comb begin
         rs      = {rem_p, bits_p[31:30]};
         tr      = {2'b00, root_p, 2'b01};
         ge      = rs >= tr;
         root_in = {root_p[30:0], ge};
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            sq_root_ff[k] <= root_in;
         end
      end

      if (k < SQRT_STEPS - 1) begin : g_rem
         logic [35:0] sub;
         logic [33:0] rem_in;

         always_comb begin
            sub    = rs - tr;
            rem_in = ge ? sub[33:0] : rs[33:0];
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               sq_rem_ff[k]  <= rem_in;
               sq_bits_ff[k] <= {bits_p[29:0], 2'b00};
            end
         end
      end
   end

   // radius = 2^48 / root
   logic [32:0] rad_quot;

   hbp_div_pipe #(
      .NUM_W (49),
      .DEN_W (32),
      .QUO_W (RAD_Q)
   ) u_radius_div (
      .clock   (clock),
      .advance (advance),
      .numer   (POW48),
      .denom   (sq_root_ff[SQRT_STEPS-1]),
      .quot    (rad_quot)
   );

   // view-space offsets
   g1_type g1_ff, g1_in;

   always_comb begin
      g1_in.dx       = {in_ff.light_x[31], in_ff.light_x} - {cam_x_ff[31], cam_x_ff};
      g1_in.dy       = {in_ff.light_y[31], in_ff.light_y} - {cam_y_ff[31], cam_y_ff};
      g1_in.dz       = {in_ff.light_z[31], in_ff.light_z} - {cam_z_ff[31], cam_z_ff};
      g1_in.hf       = in_ff.halo_fraction;
      g1_in.irs_zero = in_ff.inverse_radius_sq == '0;
   end

   // rotation products
   g2_type g2_ff, g2_in;

   always_comb begin
      g2_in.p_dc     = $signed(g1_ff.dx) * $signed(cos_ff);
      g2_in.p_ds     = $signed(g1_ff.dy) * $signed(sin_ff);
      g2_in.p_xs     = $signed(g1_ff.dx) * $signed(sin_ff);
      g2_in.p_yc     = $signed(g1_ff.dy) * $signed(cos_ff);
      g2_in.dz       = g1_ff.dz;
      g2_in.hf       = g1_ff.hf;
      g2_in.irs_zero = g1_ff.irs_zero;
   end

   // depth and lateral offset, floor of Q2.14 scaling, near test
   geo_type            geo_ff, geo_in;
   logic signed [49:0] sum_d, sum_o;

   always_comb begin
      sum_d           = $signed(g2_ff.p_dc) + $signed(g2_ff.p_ds);
      sum_o           = $signed(g2_ff.p_xs) - $signed(g2_ff.p_yc);
      geo_in.depth    = sum_d[49:14];
      geo_in.offs     = sum_o[49:14];
      geo_in.dz       = g2_ff.dz;
      geo_in.hf       = g2_ff.hf;
      geo_in.irs_zero = g2_ff.irs_zero;
      geo_in.depth_ok = $signed(geo_in.depth) >= hbp_pkg::NEAR_LIMIT;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         g1_ff  <= g1_in;
         g2_ff  <= g2_in;
         geo_ff <= geo_in;
      end
   end

   // geometry waits for the radius
   geo_type geo_dl_ff [GEO_DELAY];

   always_ff @(posedge clock) begin
      if (advance) begin
         geo_dl_ff[0] <= geo_ff;
         for (int i = 1; i < GEO_DELAY; i++) begin
            geo_dl_ff[i] <= geo_dl_ff[i-1];
         end
      end
   end

   // halo half size from radius and fraction
   h1_type      h1_ff, h1_in;
   h2_type      h2_ff, h2_in;
   logic [32:0] radius;
   logic [35:0] half_sh;

   always_comb begin
      radius    = geo_dl_ff[GEO_DELAY-1].irs_zero ? POW32 : rad_quot;
      h1_in.prod = radius * geo_dl_ff[GEO_DELAY-1].hf;
      h1_in.geo  = geo_dl_ff[GEO_DELAY-1];
      half_sh    = h1_ff.prod[48:13];
      h2_in.half = (half_sh > 36'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : half_sh[30:0];
      h2_in.geo  = h1_ff.geo;
   end

   // projection operands
   p1_type p1_ff, p1_in;
   p2_type p2_ff, p2_in;
   p3_type p3_ff, p3_in;
   logic [52:0] mag_o;
   logic [50:0] mag_a, mag_b;

   always_comb begin
      p1_in.qa       = $signed({h2_ff.geo.dz[32], h2_ff.geo.dz}) + $signed({3'b000, h2_ff.half});
      p1_in.qb       = $signed({h2_ff.geo.dz[32], h2_ff.geo.dz}) - $signed({3'b000, h2_ff.half});
      p1_in.offs     = h2_ff.geo.offs;
      p1_in.half     = h2_ff.half;
      p1_in.depth    = h2_ff.geo.depth[34:0];
      p1_in.depth_ok = h2_ff.geo.depth_ok;

      p2_in.mo       = $signed(p1_ff.offs) * $signed({1'b0, fh_ff});
      p2_in.mh       = p1_ff.half * fh_ff;
      p2_in.ma       = $signed(p1_ff.qa) * $signed({1'b0, fv_ff});
      p2_in.mb       = $signed(p1_ff.qb) * $signed({1'b0, fv_ff});
      p2_in.depth    = p1_ff.depth;
      p2_in.depth_ok = p1_ff.depth_ok;

      mag_o = p2_ff.mo[52] ? 53'(-p2_ff.mo) : 53'(p2_ff.mo);
      mag_a = p2_ff.ma[50] ? 51'(-p2_ff.ma) : 51'(p2_ff.ma);
      mag_b = p2_ff.mb[50] ? 51'(-p2_ff.mb) : 51'(p2_ff.mb);
      p3_in.num_o         = 63'(mag_o) << 12;
      p3_in.num_h         = 63'(p2_ff.mh) << 12;
      p3_in.num_a         = 63'(mag_a) << 12;
      p3_in.num_b         = 63'(mag_b) << 12;
      p3_in.depth         = p2_ff.depth;
      p3_in.side.sign_o   = p2_ff.mo[52];
      p3_in.side.sign_a   = p2_ff.ma[50];
      p3_in.side.sign_b   = p2_ff.mb[50];
      p3_in.side.depth_ok = p2_ff.depth_ok;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         h1_ff <= h1_in;
         h2_ff <= h2_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         p3_ff <= p3_in;
      end
   end

   // projection divides by depth
   logic [PROJ_Q-1:0] q_o, q_h, q_a, q_b;

   hbp_div_pipe #(.NUM_W(63), .DEN_W(35), .QUO_W(PROJ_Q)) u_div_offs (
      .clock(clock), .advance(advance), .numer(p3_ff.num_o), .denom(p3_ff.depth), .quot(q_o)
   );

   hbp_div_pipe #(.NUM_W(63), .DEN_W(35), .QUO_W(PROJ_Q)) u_div_half (
      .clock(clock), .advance(advance), .numer(p3_ff.num_h), .denom(p3_ff.depth), .quot(q_h)
   );

   hbp_div_pipe #(.NUM_W(63), .DEN_W(35), .QUO_W(PROJ_Q)) u_div_top (
      .clock(clock), .advance(advance), .numer(p3_ff.num_a), .denom(p3_ff.depth), .quot(q_a)
   );

   hbp_div_pipe #(.NUM_W(63), .DEN_W(35), .QUO_W(PROJ_Q)) u_div_bottom (
      .clock(clock), .advance(advance), .numer(p3_ff.num_b), .denom(p3_ff.depth), .quot(q_b)
   );

   // inverse depth, 2^48 / depth
   logic [IW_Q-1:0] iw_quot;

   hbp_div_pipe #(.NUM_W(49), .DEN_W(35), .QUO_W(IW_Q)) u_div_inv_depth (
      .clock(clock), .advance(advance), .numer(POW48), .denom(p3_ff.depth), .quot(iw_quot)
   );

   // signs and inverse depth wait for the projection divides
   side_type        side_dl_ff [PROJ_Q];
   logic [IW_Q-1:0] iw_dl_ff   [IW_DELAY];

   always_ff @(posedge clock) begin
      if (advance) begin
         side_dl_ff[0] <= p3_ff.side;
         for (int i = 1; i < PROJ_Q; i++) begin
            side_dl_ff[i] <= side_dl_ff[i-1];
         end
         iw_dl_ff[0] <= iw_quot;
         for (int i = 1; i < IW_DELAY; i++) begin
            iw_dl_ff[i] <= iw_dl_ff[i-1];
         end
      end
   end

   // screen edges and depth bias product
   e1_type             e1_ff, e1_in;
   side_type           side_q;
   logic signed [46:0] px_o, px_h, px_a, px_b, cx;

   always_comb begin
      side_q = side_dl_ff[PROJ_Q-1];
      px_o   = side_q.sign_o ? -47'(q_o) : 47'(q_o);
      px_h   = 47'(q_h);
      px_a   = side_q.sign_a ? -47'(q_a) : 47'(q_a);
      px_b   = side_q.sign_b ? -47'(q_b) : 47'(q_b);
      cx     = HALF_W + px_o;
      e1_in.left     = cx - px_h;
      e1_in.right    = cx + px_h;
      e1_in.top      = HALF_H - px_a;
      e1_in.bottom   = HALF_H - px_b;
      e1_in.iw       = iw_dl_ff[IW_DELAY-1];
      e1_in.zb       = nb_ff * iw_dl_ff[IW_DELAY-1];
      e1_in.depth_ok = side_q.depth_ok;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e1_ff <= e1_in;
      end
   end

   // hue divides, channel * 2^16 / intensity
   logic [HUE_Q-1:0] q_r, q_g, q_b_hue;

   hbp_div_pipe #(.NUM_W(32), .DEN_W(16), .QUO_W(HUE_Q)) u_div_red (
      .clock(clock), .advance(advance), .numer({in_ff.red_premul, 16'd0}),
      .denom(in_ff.light_intensity), .quot(q_r)
   );

   hbp_div_pipe #(.NUM_W(32), .DEN_W(16), .QUO_W(HUE_Q)) u_div_green (
      .clock(clock), .advance(advance), .numer({in_ff.green_premul, 16'd0}),
      .denom(in_ff.light_intensity), .quot(q_g)
   );

   hbp_div_pipe #(.NUM_W(32), .DEN_W(16), .QUO_W(HUE_Q)) u_div_blue (
      .clock(clock), .advance(advance), .numer({in_ff.blue_premul, 16'd0}),
      .denom(in_ff.light_intensity), .quot(q_b_hue)
   );

   // alpha and the zero intensity flag wait for the hue
   clr0_type    clr0_in;
   clr0_type    clr0_dl_ff [HUE_Q];
   logic [30:0] alpha_prod;

   always_comb begin
      alpha_prod         = 31'(hbp_pkg::C_030) * 31'(in_ff.light_intensity);
      clr0_in.inten_zero = in_ff.light_intensity == '0;
      clr0_in.alpha      = (alpha_prod[30:12] > 19'(hbp_pkg::C_042)) ?
                           hbp_pkg::C_042 : alpha_prod[26:12];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         clr0_dl_ff[0] <= clr0_in;
         for (int i = 1; i < HUE_Q; i++) begin
            clr0_dl_ff[i] <= clr0_dl_ff[i-1];
         end
      end
   end

   // pull toward white: 0.45 + 0.55 * hue, saturated
   c1_type      c1_ff, c1_in;
   clr_type     clr_in;
   logic [31:0] hue_r, hue_g, hue_b;
   logic [32:0] sh_r, sh_g, sh_b;

   always_comb begin
      hue_r = clr0_dl_ff[HUE_Q-1].inten_zero ? '0 : q_r;
      hue_g = clr0_dl_ff[HUE_Q-1].inten_zero ? '0 : q_g;
      hue_b = clr0_dl_ff[HUE_Q-1].inten_zero ? '0 : q_b_hue;
      c1_in.hr    = 48'(hbp_pkg::C_055) * 48'(hue_r);
      c1_in.hg    = 48'(hbp_pkg::C_055) * 48'(hue_g);
      c1_in.hb    = 48'(hbp_pkg::C_055) * 48'(hue_b);
      c1_in.alpha = clr0_dl_ff[HUE_Q-1].alpha;

      sh_r = 33'(hbp_pkg::C_045) + 33'(c1_ff.hr[47:16]);
      sh_g = 33'(hbp_pkg::C_045) + 33'(c1_ff.hg[47:16]);
      sh_b = 33'(hbp_pkg::C_045) + 33'(c1_ff.hb[47:16]);
      clr_in.red   = (sh_r > 33'd65535) ? 16'hFFFF : sh_r[15:0];
      clr_in.green = (sh_g > 33'd65535) ? 16'hFFFF : sh_g[15:0];
      clr_in.blue  = (sh_b > 33'd65535) ? 16'hFFFF : sh_b[15:0];
      clr_in.alpha = c1_ff.alpha;
   end

   // colour waits for the edges
   clr_type clr_dl_ff [CLR_DELAY + 1];

   always_ff @(posedge clock) begin
      if (advance) begin
         c1_ff        <= c1_in;
         clr_dl_ff[0] <= clr_in;
         for (int i = 1; i <= CLR_DELAY; i++) begin
            clr_dl_ff[i] <= clr_dl_ff[i-1];
         end
      end
   end

   // cull, clamp and biased z into the output register
   logic        on_screen;
   logic [24:0] zsh;
   clr_type     clr_out;

   always_comb begin
      clr_out   = clr_dl_ff[CLR_DELAY];
      on_screen = !(e1_ff.right[46] || (e1_ff.left > WIDTH_LIM) ||
                    e1_ff.bottom[46] || (e1_ff.top > HEIGHT_LIM));
      zsh       = e1_ff.zb[44:20];

      rsp_valid_in = valid_ff[PIPE_LAST] && e1_ff.depth_ok && on_screen;

      rsp_in.screen_left   = clamp_edge(e1_ff.left);
      rsp_in.screen_right  = clamp_edge(e1_ff.right);
      rsp_in.screen_top    = clamp_edge(e1_ff.top);
      rsp_in.screen_bottom = clamp_edge(e1_ff.bottom);
      rsp_in.shade_red     = clr_out.red;
      rsp_in.shade_green   = clr_out.green;
      rsp_in.shade_blue    = clr_out.blue;
      rsp_in.shade_alpha   = clr_out.alpha;
      rsp_in.inverse_depth = e1_ff.iw;
      if (zsh == '0) begin
         rsp_in.depth_value = 16'hFFFF;
      end else if (zsh >= 25'd65536) begin
         rsp_in.depth_value = '0;
      end else begin
         rsp_in.depth_value = 16'(25'd65536 - zsh);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
